[sv/aes_pkg.sv]
// Package with the AES constants, S-box tables and field arithmetic shared by the cipher.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

	localparam int RkWords = 60;
	localparam int RkAddrW = $clog2(RkWords);
	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_KEY0     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY1     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY2     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_KEY3     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_KEY_SIZE = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_DECRYPT  = 3'd5;

	localparam logic [1:0] KEY_128 = 2'd0;
	localparam logic [1:0] KEY_192 = 2'd1;

	typedef logic [7:0] byte_t;
	typedef logic [127:0] blk_t;

	localparam byte_t FWD_BOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam byte_t INV_BOX [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic byte_t xt(byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(logic [31:0] w);
		return {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
	endfunction

	// Byte n of the state sits at bits 127-8n down to 120-8n.
	function automatic byte_t sb(blk_t s, int n);
		return s[127-8*n -: 8];
	endfunction

	function automatic blk_t enc_round(blk_t s, logic last);
		blk_t t;
		blk_t m;
		byte_t a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127-8*(r+4*c) -: 8] = FWD_BOX[sb(s, r + 4*((c + r) % 4))];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = sb(t, 4*c);
			a1 = sb(t, 4*c+1);
			a2 = sb(t, 4*c+2);
			a3 = sb(t, 4*c+3);
			m[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			m[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			m[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			m[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
		end
		return last ? t : m;
	endfunction

	function automatic blk_t dec_sub(blk_t s);
		blk_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127-8*(r+4*c) -: 8] = INV_BOX[sb(s, r + 4*((c + 4 - r) % 4))];
			end
		end
		return t;
	endfunction

	function automatic blk_t inv_mix(blk_t s);
		blk_t m;
		byte_t a [4];
		byte_t d2 [4];
		byte_t d4 [4];
		byte_t d8 [4];
		byte_t v;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k] = sb(s, 4*c + k);
				d2[k] = xt(a[k]);
				d4[k] = xt(d2[k]);
				d8[k] = xt(d4[k]);
			end
			for (int r = 0; r < 4; r++) begin
				v = (d8[r] ^ d4[r] ^ d2[r])
					^ (d8[(r+1)%4] ^ d2[(r+1)%4] ^ a[(r+1)%4])
					^ (d8[(r+2)%4] ^ d4[(r+2)%4] ^ a[(r+2)%4])
					^ (d8[(r+3)%4] ^ a[(r+3)%4]);
				m[127-8*(4*c+r) -: 8] = v;
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

[sv/aes_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module aes_ram #(
	parameter int Width = 32,
	parameter int Depth = 60
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[sv/aes_block_cipher_top.sv]
// Top level of the iterative AES-128/192/256 block cipher.
`timescale 1ns / 1ps
`default_nettype none
// One block is enciphered or deciphered per beat. The round keys live in a
// 60-word RAM with one read port; each round reads its four words in ST_RK_RD,
// then takes the last word and applies the round in ST_RND, and the result of a
// block is registered after its initial key addition and Nr rounds. A new block
// is taken only in ST_IDLE, once the previous one has finished. After a write
// to a key register or to key_size, the first block first expands the key into
// the RAM: the Nk key words are written directly and every further word passes
// through read, RAM latency and write (ST_EXP_RD, ST_EXP_WAIT, ST_EXP_WR); this
// is done once until the next such write. A finished result is held in an
// output register while the next block is taken; if it is still waiting when the
// next result is ready, the last round stalls until it is taken.
module aes_block_cipher_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [127:0]                   s_tdata,  // block_low, block_high
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [127:0]                   m_tdata,  // result_low, result_high
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [aes_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [63:0]                    cfg_data
);
	import aes_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXP_RD, ST_EXP_WAIT, ST_EXP_WR, ST_RK_RD, ST_RND
	} state_t;

	state_t state_q;
	logic [63:0] key_q [4];
	logic [1:0] ksize_q;
	logic decrypt_q;
	logic expanded_q;
	blk_t st_q;
	logic [31:0] rk_q [4];
	logic [RkAddrW-1:0] widx_q;
	logic [RkAddrW-1:0] total_q;
	logic [3:0] nk_q;
	logic [3:0] imod_q;
	logic [7:0] rcon_q;
	logic [31:0] prev_q;
	logic [3:0] rnd_q;
	logic [3:0] nr_q;
	logic [1:0] col_q;
	logic rd_pend_q;
	logic first_q;
	logic out_valid_q;
	blk_t out_q;

	logic ram_we;
	logic [RkAddrW-1:0] ram_waddr;
	logic [31:0] ram_wdata;
	logic [RkAddrW-1:0] ram_raddr;
	logic [31:0] ram_rdata;
	logic [31:0] exp_t;
	logic [31:0] exp_word;
	logic [3:0] nk_now;
	logic [RkAddrW-1:0] rk_base;
	blk_t rk_blk;
	blk_t enc_next;
	blk_t dec_a;
	blk_t dec_next;
	logic rnd_last;

	aes_ram #(.Width(32), .Depth(RkWords)) u_rk_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign nk_now = (ksize_q == KEY_128) ? 4'd4 : ((ksize_q == KEY_192) ? 4'd6 : 4'd8);
	assign rk_base = RkAddrW'({2'b00, rnd_q} << 2);
	assign rk_blk = {rk_q[0], rk_q[1], rk_q[2], rk_q[3]};
	assign enc_next = enc_round(st_q, rnd_q == nr_q) ^ rk_blk;
	assign dec_a = dec_sub(st_q) ^ rk_blk;
	assign dec_next = (rnd_q == 4'd0) ? dec_a : inv_mix(dec_a);
	assign rnd_last = !first_q && ((decrypt_q && rnd_q == 4'd0)
		|| (!decrypt_q && rnd_q == nr_q));

	always_comb begin
		exp_t = prev_q;
		if (imod_q == 4'd0) begin
			exp_t = sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rcon_q, 24'h0};
		end else if (nk_q == 4'd8 && imod_q == 4'd4) begin
			exp_t = sub_word(prev_q);
		end
		exp_word = ram_rdata ^ exp_t;
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = widx_q;
		ram_wdata = exp_word;
		ram_raddr = rk_base + RkAddrW'(col_q);
		case (state_q)
			ST_EXP_RD: begin
				ram_raddr = widx_q - RkAddrW'(nk_q);
				if (widx_q < RkAddrW'(nk_q)) begin
					ram_we = 1'b1;
					ram_wdata = widx_q[0] ? key_q[widx_q[2:1]][31:0]
						: key_q[widx_q[2:1]][63:32];
				end
			end
			ST_EXP_WAIT: ram_raddr = widx_q - RkAddrW'(nk_q);
			ST_EXP_WR: ram_we = 1'b1;
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_q[63:0], out_q[127:64]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
			ksize_q <= '0;
			decrypt_q <= 1'b0;
			expanded_q <= 1'b0;
			out_valid_q <= 1'b0;
			rd_pend_q <= 1'b0;
			first_q <= 1'b0;
			widx_q <= '0;
			total_q <= '0;
			nk_q <= '0;
			imod_q <= '0;
			rcon_q <= '0;
			rnd_q <= '0;
			nr_q <= '0;
			col_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
						key_q[cfg_index[1:0]] <= cfg_data;
						expanded_q <= 1'b0;
					end
					REG_KEY_SIZE: begin
						ksize_q <= cfg_data[1:0];
						expanded_q <= 1'b0;
					end
					REG_DECRYPT: decrypt_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						st_q <= {s_tdata[63:0], s_tdata[127:64]};
						nr_q <= nk_now + 4'd6;
						if (expanded_q) begin
							state_q <= ST_RK_RD;
						end else begin
							state_q <= ST_EXP_RD;
						end
						rnd_q <= decrypt_q ? nk_now + 4'd6 : 4'd0;
						col_q <= '0;
						rd_pend_q <= 1'b0;
						first_q <= 1'b1;
						nk_q <= nk_now;
						total_q <= RkAddrW'({2'b00, nk_now + 4'd7} << 2);
						widx_q <= '0;
						imod_q <= '0;
						rcon_q <= 8'h01;
					end
				end
				ST_EXP_RD: begin
					if (widx_q < RkAddrW'(nk_q)) begin
						prev_q <= widx_q[0] ? key_q[widx_q[2:1]][31:0]
							: key_q[widx_q[2:1]][63:32];
						widx_q <= widx_q + 1'b1;
						if (widx_q + 1'b1 == RkAddrW'(nk_q)) begin
							imod_q <= '0;
						end
					end else if (widx_q == total_q) begin
						expanded_q <= 1'b1;
						state_q <= ST_RK_RD;
					end else begin
						state_q <= ST_EXP_WAIT;
					end
				end
				ST_EXP_WAIT: state_q <= ST_EXP_WR;
				ST_EXP_WR: begin
					prev_q <= exp_word;
					if (imod_q == 4'd0) begin
						rcon_q <= xt(rcon_q);
					end
					imod_q <= (imod_q + 4'd1 == nk_q) ? 4'd0 : imod_q + 4'd1;
					widx_q <= widx_q + 1'b1;
					state_q <= ST_EXP_RD;
				end
				ST_RK_RD: begin
					rd_pend_q <= 1'b1;
					col_q <= col_q + 1'b1;
					if (rd_pend_q) begin
						rk_q[col_q - 2'd1] <= ram_rdata;
					end
					if (col_q == 2'd3) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					if (rd_pend_q) begin
						rk_q[3] <= ram_rdata;
						rd_pend_q <= 1'b0;
					end else if (!rnd_last || !out_valid_q || m_tready) begin
						first_q <= 1'b0;
						col_q <= '0;
						if (first_q) begin
							st_q <= st_q ^ rk_blk;
						end else if (decrypt_q) begin
							st_q <= dec_next;
						end else begin
							st_q <= enc_next;
						end
						if (rnd_last) begin
							out_q <= decrypt_q ? dec_next : enc_next;
							out_valid_q <= 1'b1;
							state_q <= ST_IDLE;
						end else if (first_q) begin
							rnd_q <= decrypt_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
							state_q <= ST_RK_RD;
						end else begin
							rnd_q <= decrypt_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
							state_q <= ST_RK_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready) else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND) |-> (rnd_q <= nr_q)) else $error("round out of range");

endmodule
`default_nettype wire

[verif/aes_block_cipher_checker.sv]
// Checker that predicts the AES block cipher results and compares them with the output beats.
`timescale 1ns / 1ps
module aes_block_cipher_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [127:0]                   s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [127:0]                   m_tdata,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [aes_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [63:0]                    cfg_data,
	output int                             errors,
	output int                             pending,
	output int                             results_seen
);
	import aes_pkg::*;

	logic [63:0] key_reg [4];
	logic [1:0]  key_size;
	logic        decrypt;
	logic [127:0] cipher_q [$];

	function automatic byte_t gf_mult(byte_t a, byte_t b);
		byte_t acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return acc;
	endfunction

	function automatic blk_t box_bytes(blk_t st, logic inv);
		for (int n = 0; n < 16; n++)
			st[127-8*n -: 8] = inv ? INV_BOX[st[127-8*n -: 8]] : FWD_BOX[st[127-8*n -: 8]];
		return st;
	endfunction

	function automatic blk_t rotate_rows(blk_t st, logic inv);
		blk_t t;
		int src;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
				t[127-8*(r+4*c) -: 8] = st[127-8*(r+4*src) -: 8];
			end
		end
		return t;
	endfunction

	function automatic blk_t mix_cols(blk_t st, logic inv);
		blk_t t;
		byte_t coef [4];
		byte_t v;
		if (inv)
			coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		else
			coef = '{8'h02, 8'h03, 8'h01, 8'h01};
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				v = 8'h00;
				for (int k = 0; k < 4; k++)
					v ^= gf_mult(st[127-8*(4*c+k) -: 8], coef[(k + 4 - r) % 4]);
				t[127-8*(4*c+r) -: 8] = v;
			end
		end
		return t;
	endfunction

	// Takes and returns blocks with byte 0 in the top bits.
	function automatic blk_t cipher_block(blk_t blk);
		logic [31:0] w [60];
		blk_t rk [15];
		logic [31:0] tmp;
		byte_t rc;
		int nk, nr, total;
		blk_t st;
		nk = (key_size == KEY_128) ? 4 : ((key_size == KEY_192) ? 6 : 8);
		nr = nk + 6;
		total = 4 * (nr + 1);
		rc = 8'h01;
		for (int i = 0; i < nk; i++)
			w[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
		for (int i = nk; i < total; i++) begin
			tmp = w[i-1];
			if (i % nk == 0) begin
				tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rc, 24'h0};
				rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
			end else if (nk == 8 && i % nk == 4) begin
				tmp = sub_word(tmp);
			end
			w[i] = w[i-nk] ^ tmp;
		end
		for (int r = 0; r <= nr; r++)
			rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
		st = blk;
		if (!decrypt) begin
			st ^= rk[0];
			for (int r = 1; r <= nr; r++) begin
				st = rotate_rows(box_bytes(st, 1'b0), 1'b0);
				if (r != nr)
					st = mix_cols(st, 1'b0);
				st ^= rk[r];
			end
		end else begin
			st ^= rk[nr];
			for (int r = nr - 1; r >= 0; r--) begin
				st = box_bytes(rotate_rows(st, 1'b1), 1'b1) ^ rk[r];
				if (r != 0)
					st = mix_cols(st, 1'b1);
			end
		end
		return st;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] want;
		logic [127:0] blk;
		if (!arst_n) begin
			key_reg = '{default: 64'h0};
			key_size = KEY_128;
			decrypt = 1'b0;
			cipher_q.delete();
			errors = 0;
			pending = 0;
			results_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_reg[cfg_index[1:0]] = cfg_data;
					REG_KEY_SIZE: key_size = cfg_data[1:0];
					REG_DECRYPT: decrypt = cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				blk = cipher_block({s_tdata[63:0], s_tdata[127:64]});
				cipher_q.push_back({blk[63:0], blk[127:64]});
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (cipher_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat %h", $time, m_tdata);
				end else begin
					want = cipher_q.pop_front();
					if (want[63:0] !== m_tdata[63:0]) begin
						errors++;
						$display("%0t: result_high expected %h actual %h", $time,
							want[63:0], m_tdata[63:0]);
					end
					if (want[127:64] !== m_tdata[127:64]) begin
						errors++;
						$display("%0t: result_low expected %h actual %h", $time,
							want[127:64], m_tdata[127:64]);
					end
				end
			end
			pending = cipher_q.size();
		end
	end

endmodule

[verif/testbench.sv]
// Top of the AES block cipher testbench: stimulus, flow control and the verdict.
`timescale 1ns / 1ps
module testbench;
	import aes_pkg::*;

	localparam logic [CfgIdxW-1:0] REG_SPARE6 = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_SPARE7 = 3'd7;
	localparam logic [1:0] KEY_256 = 2'd2;
	localparam int CycleLimit = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	int errors, pending, results_seen;
	int send_idle = 0;
	int recv_stall = 0;
	logic recv_hold = 1'b0;
	int cycles = 0;
	int blocks_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	aes_block_cipher_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	aes_block_cipher_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	always @(posedge clk) begin
		m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall);
		cycles++;
		if (cycles > CycleLimit) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_block(logic [63:0] hi, logic [63:0] lo);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {lo, hi};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		blocks_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
			logic [63:0] k3, logic [1:0] ks, logic mode);
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KEY3, k3);
		write_reg(REG_KEY_SIZE, {62'h0, ks});
		write_reg(REG_DECRYPT, {63'h0, mode});
		@(posedge clk);
	endtask

	initial begin
		logic [63:0] kfill;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset key first, then every key size in both directions with fixed patterned keys.
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		drain();
		for (int ks = 0; ks < 4; ks++) begin
			for (int mode = 0; mode < 2; mode++) begin
				kfill = mode ? '1 : 64'h0123456789abcdef;
				load_key(kfill, ~kfill, kfill, ~kfill, ks[1:0], mode[0]);
				send_block(64'h0, '1);
				send_block(64'h8000000000000001, 64'h5555aaaa5555aaaa);
				drain();
			end
		end
		// Spare register indexes must be ignored; the result must not change.
		write_reg(REG_SPARE6, '1);
		write_reg(REG_SPARE7, '1);
		send_block('1, 64'h0);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 53; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 53; end
				default: begin send_idle = 7; recv_stall = 7; end
			endcase
			if (ph % 3 == 2) begin
				write_reg(REG_DECRYPT, {63'h0, ~u_checker.decrypt});
				@(posedge clk);
			end else begin
				load_key(rand64(), rand64(), rand64(), rand64(),
					(ph == 4) ? KEY_256 : 2'($urandom_range(3)), 1'($urandom_range(1)));
			end
			if (ph == 3) begin
				fork
					begin
						recv_hold = 1'b1;
						repeat (600) @(posedge clk);
						recv_hold = 1'b0;
					end
				join_none
			end
			for (int n = 0; n < 85; n++) begin
				if (ph == 5 && n == 40)
					drain();
				send_block(rand64(), rand64());
			end
			drain();
		end
		$display("Sent %0d blocks and checked %0d results over all key sizes,", blocks_sent,
			results_seen);
		$display("both directions, key rewrites, mode-only changes and flow-control stalls.");
		if (errors == 0 && pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

[sim.f]
sv/aes_pkg.sv
sv/aes_ram.sv
sv/aes_block_cipher_top.sv
verif/aes_block_cipher_checker.sv
verif/testbench.sv
